// ===== rtl/swmma_pkg.sv =====
// Package for the sliding window min / max / mean block.
// Holds the register map constants and the fixed register field widths.
// Depends on nothing.
package swmma_pkg;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int AVG_REG_BITS  = 6;

   localparam logic [AVG_REG_BITS-1:0] AVG_COUNT_RESET = AVG_REG_BITS'(50);

   localparam logic [CSR_ADDR_BITS-3:0] REG_AVG_COUNT = '0;

endpackage

// ===== rtl/swmma_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the sample history. Depends on nothing.
module swmma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 50,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sliding_window_min_max_average.sv =====
// Sliding window min / max / mean over the newest WINDOW samples.
// Depends on swmma_pkg and swmma_ram.
//
// Usage:
// A sample enters on the req_ channel when req_valid is high and req_stall is
// low. The block then raises req_stall until the result has moved into the
// output register, so one request is processed at a time.
// Each request pushes the sample into a circular history held in one RAM and
// returns one result on the rsp_ channel: the window maximum floored at zero,
// the window minimum capped at zero, and the mean of the newest avg_count
// samples, truncated toward zero. An avg_count of zero is taken as one, and
// one above WINDOW as WINDOW. The work of a request is a scan of the history
// through the single RAM read port, one entry per cycle, followed by a
// restoring divide that produces one quotient bit per cycle. The result then
// moves into the output register when that is free; rsp_valid rises and
// req_stall falls in the same cycle, so the next request can be taken.
// If the receiver stalls, the result waits in the output register while the
// next request is accepted and processed; that request then waits at its end
// until the output register is free.
// Reset clears the fill count, so every history entry reads as zero until it
// is written; no clearing pass is needed. avg_count resets to 50 and is
// written through the csr_ port at byte address 0.
module sliding_window_min_max_average #(
   parameter int WINDOW      = 50,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [SAMPLE_BITS-2:0]               rsp_window_max,
   output logic signed [SAMPLE_BITS-1:0]        rsp_window_min,
   output logic signed [SAMPLE_BITS-1:0]        rsp_window_mean,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swmma_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [swmma_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [swmma_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   import swmma_pkg::*;

   localparam int ADDR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int AGE_BITS  = $clog2(WINDOW + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + AGE_BITS;
   localparam int DCNT_BITS = $clog2(SUM_BITS);

   localparam logic [ADDR_BITS-1:0] LAST_ADDR  = ADDR_BITS'(WINDOW - 1);
   localparam logic [AGE_BITS-1:0]  WINDOW_AGE = AGE_BITS'(WINDOW);
   localparam logic [AGE_BITS-1:0]  LAST_AGE   = AGE_BITS'(WINDOW - 1);
   localparam logic [DCNT_BITS-1:0] LAST_STEP  = DCNT_BITS'(SUM_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   logic [AVG_REG_BITS-1:0]      avg_count_ff;
   logic [ADDR_BITS-1:0]         wp_ff;
   logic [ADDR_BITS-1:0]         rd_addr_ff;
   logic [AGE_BITS-1:0]          fill_ff;
   logic [AGE_BITS-1:0]          count_ff;
   logic [AGE_BITS-1:0]          issue_age_ff;
   logic [AGE_BITS-1:0]          data_age_ff;
   logic                         data_vld_ff;
   logic signed [SAMPLE_BITS-1:0] hi_ff;
   logic signed [SAMPLE_BITS-1:0] lo_ff;
   logic signed [SUM_BITS-1:0]   sum_ff;
   logic [SUM_BITS-1:0]          dvd_ff;
   logic [AGE_BITS-1:0]          rem_ff;
   logic                         neg_ff;
   logic [DCNT_BITS-1:0]         step_ff;
   logic                         rsp_valid_ff;
   logic [SAMPLE_BITS-2:0]       max_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] mean_ff;

   logic                         req_accept;
   logic                         csr_write;
   logic [AGE_BITS-1:0]          count_in;
   logic [SAMPLE_BITS-1:0]       ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] entry;
   logic signed [SUM_BITS-1:0]   sum_in;
   logic [AGE_BITS:0]            rem_shift;
   logic [AGE_BITS:0]            rem_diff;
   logic                         quot_bit;
   logic [AGE_BITS-1:0]          rem_in;
   logic [SUM_BITS-1:0]          dvd_in;
   logic [SUM_BITS-1:0]          sum_mag;
   logic [SAMPLE_BITS-1:0]       quot_low;
   logic signed [SAMPLE_BITS-1:0] mean_in;
   logic                         out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_BITS-1:2] == REG_AVG_COUNT);
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_AVG_COUNT) ?
                       CSR_DATA_BITS'(avg_count_ff) : '0;

   always_comb begin
      if (avg_count_ff == '0) begin
         count_in = AGE_BITS'(1);
      end else if (32'(avg_count_ff) > 32'(WINDOW)) begin
         count_in = WINDOW_AGE;
      end else begin
         count_in = AGE_BITS'(avg_count_ff);
      end
   end

   swmma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // Entries beyond the fill count have never been written and read as zero.
   assign entry  = (data_age_ff < fill_ff) ? $signed(ram_rd_data) : '0;
   assign sum_in = (data_age_ff < count_ff) ? (sum_ff + SUM_BITS'(entry)) : sum_ff;

   assign rem_shift = {rem_ff, dvd_ff[SUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, count_ff};
   assign quot_bit  = (rem_shift >= {1'b0, count_ff});
   assign rem_in    = quot_bit ? rem_diff[AGE_BITS-1:0] : rem_shift[AGE_BITS-1:0];
   assign dvd_in    = {dvd_ff[SUM_BITS-2:0], quot_bit};

   assign sum_mag  = sum_ff[SUM_BITS-1] ? (SUM_BITS'(0) - $unsigned(sum_ff))
                                        : $unsigned(sum_ff);
   assign quot_low = dvd_ff[SAMPLE_BITS-1:0];
   assign mean_in  = neg_ff ? $signed(SAMPLE_BITS'(0) - quot_low) : $signed(quot_low);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_count_ff <= AVG_COUNT_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            avg_count_ff <= csr_pwdata[AVG_REG_BITS-1:0];
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         data_vld_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff     <= ST_SCAN;
                  rd_addr_ff   <= wp_ff;
                  wp_ff        <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
                  if (fill_ff != WINDOW_AGE) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
                  count_ff     <= count_in;
                  issue_age_ff <= '0;
                  hi_ff        <= '0;
                  lo_ff        <= '0;
                  sum_ff       <= '0;
               end
            end
            ST_SCAN: begin
               if (issue_age_ff != WINDOW_AGE) begin
                  data_vld_ff  <= 1'b1;
                  data_age_ff  <= issue_age_ff;
                  issue_age_ff <= issue_age_ff + 1'b1;
                  rd_addr_ff   <= (rd_addr_ff == '0) ? LAST_ADDR : rd_addr_ff - 1'b1;
               end
               if (data_vld_ff) begin
                  if (entry > hi_ff) begin
                     hi_ff <= entry;
                  end
                  if (entry < lo_ff) begin
                     lo_ff <= entry;
                  end
                  sum_ff <= sum_in;
                  if (data_age_ff == LAST_AGE) begin
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               state_ff <= ST_DIVIDE;
               neg_ff   <= sum_ff[SUM_BITS-1];
               dvd_ff   <= sum_mag;
               rem_ff   <= '0;
               step_ff  <= '0;
            end
            ST_DIVIDE: begin
               dvd_ff  <= dvd_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  max_ff       <= hi_ff[SAMPLE_BITS-2:0];
                  min_ff       <= lo_ff;
                  mean_ff      <= mean_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_max  = max_ff;
   assign rsp_window_min  = min_ff;
   assign rsp_window_mean = mean_ff;

   // The remainder of the restoring divide always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < count_ff))
      else $error("divide remainder not below divisor");

   // The mean divisor is never zero and never exceeds the window.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0 && count_ff <= WINDOW_AGE))
      else $error("mean divisor out of range");

   // The fill count saturates at the window length.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WINDOW_AGE)
      else $error("fill count beyond window");

   // A new result is only loaded at the end of a divide.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside the final state");

   // An accepted request always starts a scan in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN && issue_age_ff == '0))
      else $error("accepted request did not start a scan");

endmodule
